// ===== hdl/xtea_block_encrypt_core_defines.svh =====
// assertion macros for the xtea block encrypt core
// no dependencies; included by files that carry concurrent checks
`ifndef XTEA_BLOCK_ENCRYPT_CORE_DEFINES_SVH
`define XTEA_BLOCK_ENCRYPT_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// implication style check, disabled while in reset
`define XBE_ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("xtea core check failed");
// condition that must never be seen at a clock edge
`define XBE_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("xtea core forbidden condition");
`else
`define XBE_ASSERT_PROP(label, clk, rst_n, prop)
`define XBE_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== hdl/xtea_pkg.sv =====
// shared types, constants and key schedule helper for the xtea core
// no dependencies
package xtea_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [3:0] key_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_WORD_0 = 3'd0,
    REG_KEY_WORD_1 = 3'd1,
    REG_KEY_WORD_2 = 3'd2,
    REG_KEY_WORD_3 = 3'd3
  } cfg_reg_t;

  // block travelling through the cell chain
  typedef struct packed {
    word_t left;
    word_t right;
    logic  fin;
  } blk_t;

  // output buffer status seen by the top level
  typedef struct packed {
    logic out_full;
    logic skid_full;
  } obuf_status_t;

  // schedule sum after a given number of delta steps, modulo 2^32
  function automatic word_t sched_sum(input int unsigned steps);
    logic [63:0] prod;
    prod = 64'(steps) * 64'(DELTA);
    return prod[WORD_W-1:0];
  endfunction

endpackage

// ===== hdl/xtea_if.sv =====
// valid/ready channel interfaces for plaintext and ciphertext words
// depends on xtea_pkg
interface xtea_in_if;
  logic               valid;
  logic               ready;
  xtea_pkg::word_t    plain_left;
  xtea_pkg::word_t    plain_right;
  logic               final_block;

  modport source (output valid, output plain_left, output plain_right,
                  output final_block, input ready);
  modport sink   (input valid, input plain_left, input plain_right,
                  input final_block, output ready);
endinterface

interface xtea_out_if;
  logic               valid;
  logic               ready;
  xtea_pkg::word_t    cipher_left;
  xtea_pkg::word_t    cipher_right;
  logic               final_out;

  modport source (output valid, output cipher_left, output cipher_right,
                  output final_out, input ready);
  modport sink   (input valid, input cipher_left, input cipher_right,
                  input final_out, output ready);
endinterface

// ===== hdl/xtea_cell.sv =====
// one feistel half-round cell of the xtea chain
// depends on xtea_pkg; schedule sum and key slot fixed at elaboration
module xtea_cell #(
  parameter bit          ODD_HALF  = 1'b0,
  parameter logic [31:0] ROUND_SUM = 32'h0000_0000
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  xtea_pkg::blk_t  in_blk,
  input  xtea_pkg::key_t  key,
  output logic            out_valid,
  output xtea_pkg::blk_t  out_blk
);

  // even half uses sum bits 1:0, odd half uses sum bits 12:11
  localparam logic [1:0] KEY_IDX = ODD_HALF ? ROUND_SUM[12:11] : ROUND_SUM[1:0];

  logic            valid_r;
  xtea_pkg::blk_t  blk_r;
  xtea_pkg::blk_t  blk_nxt;
  xtea_pkg::word_t mix_src;
  xtea_pkg::word_t mix_val;
  xtea_pkg::word_t sched_val;

  // half-round mixing
  always_comb begin
    mix_src   = ODD_HALF ? in_blk.left : in_blk.right;
    mix_val   = ((mix_src << 4) ^ (mix_src >> 5)) + mix_src;
    sched_val = ROUND_SUM + key[KEY_IDX];
    blk_nxt   = in_blk;
    if (ODD_HALF) begin
      blk_nxt.right = in_blk.right + (mix_val ^ sched_val);
    end else begin
      blk_nxt.left = in_blk.left + (mix_val ^ sched_val);
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  // word register
  always_ff @(posedge clk) begin
    if (en) begin
      blk_r <= blk_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_blk   = blk_r;

endmodule

// ===== hdl/xtea_obuf.sv =====
// two-entry output buffer (output register plus skid) after the cell chain
// depends on xtea_pkg; its enable freezes the whole chain while the skid is full
module xtea_obuf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  last_valid,
  input  xtea_pkg::blk_t        last_blk,
  output logic                  pipe_en,
  output xtea_pkg::obuf_status_t status,
  output logic                  out_valid,
  output xtea_pkg::blk_t        out_blk,
  input  logic                  out_ready
);

  logic           out_v_r;
  logic           out_v_nxt;
  logic           skid_v_r;
  logic           skid_v_nxt;
  xtea_pkg::blk_t out_blk_r;
  xtea_pkg::blk_t skid_blk_r;
  logic           push;
  logic           pop;
  logic           load_out;
  logic           load_skid;
  logic           skid_to_out;

  assign pipe_en = !skid_v_r;
  assign push    = last_valid && pipe_en;
  assign pop     = out_v_r && out_ready;

  // buffer control
  always_comb begin
    out_v_nxt   = out_v_r;
    skid_v_nxt  = skid_v_r;
    load_out    = 1'b0;
    load_skid   = 1'b0;
    skid_to_out = 1'b0;
    priority if (skid_v_r) begin
      if (pop) begin
        skid_to_out = 1'b1;
        skid_v_nxt  = 1'b0;
      end
    end else if (push) begin
      if (!out_v_r || pop) begin
        load_out  = 1'b1;
        out_v_nxt = 1'b1;
      end else begin
        load_skid  = 1'b1;
        skid_v_nxt = 1'b1;
      end
    end else if (pop) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  // word storage
  always_ff @(posedge clk) begin
    if (skid_to_out) begin
      out_blk_r <= skid_blk_r;
    end else if (load_out) begin
      out_blk_r <= last_blk;
    end
    if (load_skid) begin
      skid_blk_r <= last_blk;
    end
  end

  assign out_valid        = out_v_r;
  assign out_blk          = out_blk_r;
  assign status.out_full  = out_v_r;
  assign status.skid_full = skid_v_r;

endmodule

// ===== hdl/xtea_block_encrypt_core.sv =====
// xtea encryption core, throughput one 64-bit word per cycle while not stalled
// a chain of 2*CYCLE_COUNT half-round cells
// each holds one word, and a two-entry output buffer stalls the chain when full
// rst_n (synchronous, active low) empties the chain and buffer, zeroes the key
// depends on xtea_pkg, xtea_if, xtea_cell, xtea_obuf and the defines header
`include "xtea_block_encrypt_core_defines.svh"
module xtea_block_encrypt_core #(
  parameter int unsigned CYCLE_COUNT = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  xtea_in_if.sink                            in_ch,
  xtea_out_if.source                         out_ch,
  input  logic                               cfg_wr_en,
  input  logic [xtea_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  xtea_pkg::word_t                    cfg_wdata
);

  localparam int unsigned STAGES = 2 * CYCLE_COUNT;

  xtea_pkg::key_t         key_r;
  xtea_pkg::key_t         key_nxt;
  logic                   pipe_en;
  logic                   valid_s [0:STAGES];
  xtea_pkg::blk_t         blk_s   [0:STAGES];
  xtea_pkg::blk_t         out_blk;
  xtea_pkg::obuf_status_t obuf_status;
  logic                   stall_push;

  // key register writes
  always_comb begin
    key_nxt = key_r;
    if (cfg_wr_en) begin
      unique case (xtea_pkg::cfg_reg_t'(cfg_index))
        xtea_pkg::REG_KEY_WORD_0: key_nxt[0] = cfg_wdata;
        xtea_pkg::REG_KEY_WORD_1: key_nxt[1] = cfg_wdata;
        xtea_pkg::REG_KEY_WORD_2: key_nxt[2] = cfg_wdata;
        xtea_pkg::REG_KEY_WORD_3: key_nxt[3] = cfg_wdata;
        default: key_nxt = key_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else begin
      key_r <= key_nxt;
    end
  end

  // chain head
  assign in_ch.ready        = pipe_en;
  assign valid_s[0]         = in_ch.valid;
  assign blk_s[0].left      = in_ch.plain_left;
  assign blk_s[0].right     = in_ch.plain_right;
  assign blk_s[0].fin       = in_ch.final_block;

  // half-round cells, sum fixed per cell
  for (genvar k = 0; k < STAGES; k++) begin : g_cell
    xtea_cell #(
      .ODD_HALF  ((k % 2) == 1),
      .ROUND_SUM (xtea_pkg::sched_sum(k / 2 + k % 2))
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (pipe_en),
      .in_valid  (valid_s[k]),
      .in_blk    (blk_s[k]),
      .key       (key_r),
      .out_valid (valid_s[k+1]),
      .out_blk   (blk_s[k+1])
    );
  end

  // output buffer
  xtea_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .last_valid (valid_s[STAGES]),
    .last_blk   (blk_s[STAGES]),
    .pipe_en    (pipe_en),
    .status     (obuf_status),
    .out_valid  (out_ch.valid),
    .out_blk    (out_blk),
    .out_ready  (out_ch.ready)
  );

  assign out_ch.cipher_left  = out_blk.left;
  assign out_ch.cipher_right = out_blk.right;
  assign out_ch.final_out    = out_blk.fin;

  // word arriving while the output register is held
  assign stall_push = valid_s[STAGES] && pipe_en && obuf_status.out_full && !out_ch.ready;

  // checks
  `XBE_ASSERT_PROP(a_skid_implies_out, clk, rst_n, obuf_status.skid_full |-> obuf_status.out_full)
  `XBE_ASSERT_PROP(a_accept_enters, clk, rst_n, (in_ch.valid && in_ch.ready) |=> valid_s[1])
  `XBE_ASSERT_PROP(a_stall_fills_skid, clk, rst_n, stall_push |=> obuf_status.skid_full)

endmodule

// ===== verif/tb_xtea_block_encrypt_core.sv =====
// self-checking testbench for xtea_block_encrypt_core: 64-bit block encryption
// under several keys, checked against an in-bench xtea predictor
// depends on xtea_pkg, xtea_if and the core rtl
`timescale 1ns / 100ps
module tb_xtea_block_encrypt_core;

  localparam int unsigned CYCLE_COUNT  = 32;
  localparam int unsigned PIPE_LATENCY = 2 * CYCLE_COUNT + 1;
  localparam int unsigned PHASE_WORDS  = 64;
  localparam int unsigned KEY_PHASES   = 6;
  // register indexes past the key words, writes there must be dropped
  localparam logic [xtea_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE =
    xtea_pkg::CFG_IDX_W'(xtea_pkg::REG_KEY_WORD_3) + 1'b1;
  localparam logic [xtea_pkg::CFG_IDX_W-1:0] CFG_IDX_TOP   = '1;

  typedef enum int {
    IDLE_SEND_LIGHT,  // sender 32 of 100, receiver 84 of 100
    IDLE_SEND_HEAVY,  // sender 84 of 100, receiver 32 of 100
    IDLE_NONE
  } idle_mode_t;

  // directed plaintext words: extremes, walking bits, patterns
  localparam xtea_pkg::blk_t PLAIN_TABLE [12] = '{
    {32'h0000_0000, 32'h0000_0000, 1'b0},
    {32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1},
    {32'h0000_0000, 32'hFFFF_FFFF, 1'b0},
    {32'hFFFF_FFFF, 32'h0000_0000, 1'b1},
    {32'h8000_0000, 32'h0000_0001, 1'b0},
    {32'h0000_0001, 32'h8000_0000, 1'b1},
    {32'hAAAA_AAAA, 32'h5555_5555, 1'b0},
    {32'h5555_5555, 32'hAAAA_AAAA, 1'b1},
    {32'h4443_4241, 32'h4847_4645, 1'b0},
    {32'h7FFF_FFFF, 32'h8000_0000, 1'b1},
    {32'hFEDC_BA98, 32'h7654_3210, 1'b0},
    {32'h0123_4567, 32'h89AB_CDEF, 1'b1}
  };

  logic clk;
  logic rst_n;
  logic                           cfg_wr_en;
  logic [xtea_pkg::CFG_IDX_W-1:0] cfg_index;
  xtea_pkg::word_t                cfg_wdata;

  xtea_in_if  in_ch ();
  xtea_out_if out_ch ();

  xtea_block_encrypt_core #(
    .CYCLE_COUNT(CYCLE_COUNT)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // predictor key copy and expected cipher words in order of acceptance
  xtea_pkg::word_t key_q [4];
  xtea_pkg::blk_t  cipher_fifo [$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned words_sent;
  int unsigned words_checked = 0;
  int unsigned key_loads;
  int unsigned mismatch_count = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // xtea encryption of one block under the predictor key
  function automatic xtea_pkg::blk_t xtea_encrypt(input xtea_pkg::blk_t plain);
    xtea_pkg::word_t v0;
    xtea_pkg::word_t v1;
    xtea_pkg::word_t sched;
    xtea_pkg::blk_t  res;
    v0    = plain.left;
    v1    = plain.right;
    sched = '0;
    for (int i = 0; i < CYCLE_COUNT; i++) begin
      v0 += (((v1 << 4) ^ (v1 >> 5)) + v1) ^ (sched + key_q[sched[1:0]]);
      sched += xtea_pkg::DELTA;
      v1 += (((v0 << 4) ^ (v0 >> 5)) + v0) ^ (sched + key_q[sched[12:11]]);
    end
    res.left  = v0;
    res.right = v1;
    res.fin   = plain.fin;
    return res;
  endfunction

  // biased toward extremes, single set bits and single cleared bits
  function automatic xtea_pkg::word_t pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return xtea_pkg::word_t'(1) << $urandom_range(0, xtea_pkg::WORD_W - 1);
      3: return ~(xtea_pkg::word_t'(1) << $urandom_range(0, xtea_pkg::WORD_W - 1));
      default: return $urandom();
    endcase
  endfunction

  function automatic void set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_SEND_LIGHT: begin
        send_idle_pct = 32;
        recv_idle_pct = 84;
      end
      IDLE_SEND_HEAVY: begin
        send_idle_pct = 84;
        recv_idle_pct = 32;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endfunction

  // entered and left at a falling edge; valid stays high into the next word
  task automatic send_word(input xtea_pkg::blk_t plain);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.plain_left  <= plain.left;
    in_ch.plain_right <= plain.right;
    in_ch.final_block <= plain.fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    cipher_fifo.push_back(xtea_encrypt(plain));
    words_sent++;
    @(negedge clk);
  endtask

  // register write at the next rising edge; caller drops the enable
  task automatic write_reg(input logic [xtea_pkg::CFG_IDX_W-1:0] idx,
                           input xtea_pkg::word_t data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    if (idx <= xtea_pkg::REG_KEY_WORD_3) key_q[idx[1:0]] = data;
  endtask

  // stop sending and let every expected word come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (cipher_fifo.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver backpressure
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // compare each accepted output word with the oldest expectation
  always @(posedge clk) begin
    xtea_pkg::blk_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (cipher_fifo.size() == 0) begin
        $error("unexpected output word: left %h right %h final %b",
               out_ch.cipher_left, out_ch.cipher_right, out_ch.final_out);
        mismatch_count++;
      end else begin
        want = cipher_fifo.pop_front();
        words_checked++;
        if (out_ch.cipher_left !== want.left) begin
          $error("cipher_left: expected %h, got %h", want.left, out_ch.cipher_left);
          mismatch_count++;
        end
        if (out_ch.cipher_right !== want.right) begin
          $error("cipher_right: expected %h, got %h", want.right, out_ch.cipher_right);
          mismatch_count++;
        end
        if (out_ch.final_out !== want.fin) begin
          $error("final_out: expected %b, got %b", want.fin, out_ch.final_out);
          mismatch_count++;
        end
      end
    end
  end

  // main sequence
  initial begin
    xtea_pkg::word_t key_plan [4];
    xtea_pkg::blk_t  plain;
    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.plain_left  = '0;
    in_ch.plain_right = '0;
    in_ch.final_block = 1'b0;
    foreach (key_q[i]) key_q[i] = '0;
    words_sent     = 0;
    key_loads      = 0;
    set_idle(IDLE_SEND_LIGHT);

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed words with the key never written
    foreach (PLAIN_TABLE[i]) send_word(PLAIN_TABLE[i]);
    drain();

    // writes past the key words must leave the key at zero
    write_reg(CFG_IDX_SPARE, '1);
    write_reg(CFG_IDX_TOP, 32'hA5A5_5A5A);
    cfg_wr_en <= 1'b0;
    foreach (PLAIN_TABLE[i]) send_word(PLAIN_TABLE[i]);
    drain();

    // random words under a series of keys, idling pattern changes every two keys
    for (int p = 0; p < KEY_PHASES; p++) begin
      case (p)
        0: key_plan = '{'1, '1, '1, '1};
        1: key_plan = '{'0, '1, '0, '1};
        2: key_plan = '{32'h0302_0100, 32'h0706_0504, 32'h0B0A_0908, 32'h0F0E_0D0C};
        default: foreach (key_plan[k]) key_plan[k] = pick_word();
      endcase
      set_idle(idle_mode_t'(p / 2));
      write_reg(xtea_pkg::REG_KEY_WORD_0, key_plan[0]);
      write_reg(xtea_pkg::REG_KEY_WORD_1, key_plan[1]);
      write_reg(xtea_pkg::REG_KEY_WORD_2, key_plan[2]);
      write_reg(xtea_pkg::REG_KEY_WORD_3, key_plan[3]);
      write_reg(xtea_pkg::CFG_IDX_W'($urandom_range(CFG_IDX_SPARE, CFG_IDX_TOP)),
                $urandom());
      cfg_wr_en <= 1'b0;
      key_loads++;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        plain.left  = pick_word();
        plain.right = pick_word();
        plain.fin   = ($urandom_range(0, 3) == 0);
        send_word(plain);
      end
      drain();
    end

    // catch any stray output after the last expected word
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    $display("sent %0d blocks, checked %0d cipher words", words_sent, words_checked);
    $display("keys: reset value, ignored spare writes, %0d programmed keys", key_loads);
    if (mismatch_count == 0) begin
      $display("tb_xtea_block_encrypt_core passed");
    end else begin
      $display("tb_xtea_block_encrypt_core failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("tb_xtea_block_encrypt_core failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/xtea_pkg.sv
hdl/xtea_if.sv
hdl/xtea_cell.sv
hdl/xtea_obuf.sv
hdl/xtea_block_encrypt_core.sv
verif/tb_xtea_block_encrypt_core.sv
